/* rtl/snell_slowness_horizontal_interface_defines.svh */
// assertion macros for the snell slowness interface block
`ifndef SNELL_SLOWNESS_HORIZONTAL_INTERFACE_DEFINES_SVH
`define SNELL_SLOWNESS_HORIZONTAL_INTERFACE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SSH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed in same cycle");

// antecedent implies consequent in the next cycle
`define SSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed in next cycle");

`endif

/* rtl/ssh_pkg.sv */
// shared types and constants of the snell slowness interface block
package ssh_pkg;

    localparam int SLOW_W          = 48;
    localparam int HALF_W          = 24;
    localparam int MSQ_W           = 95;
    localparam int OUT_TDATA_W     = 144;
    localparam int STEPS_PER_STAGE = 4;

    localparam logic [SLOW_W-1:0] SLOW_MAX = {1'b0, {(SLOW_W-1){1'b1}}};
    localparam logic [SLOW_W-1:0] SLOW_MIN = {1'b1, {(SLOW_W-1){1'b0}}};

    typedef enum logic {
        OP_TRANSMIT = 1'b0,
        OP_REFLECT  = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              neg;
        logic [SLOW_W-1:0] sx;
        logic [SLOW_W-1:0] sy;
        logic [SLOW_W-1:0] refl;
    } t_side;

endpackage

/* rtl/ssh_recip.sv */
// pipelined restoring divider giving floor(2^(2f) / d)
module ssh_recip #(
    parameter int FRAC_BITS = 40,
    parameter int VEL_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_ce,
    input  logic [2*VEL_BITS-1:0]    i_d,
    output logic [2*FRAC_BITS:0]     o_q
);

    localparam int DW  = 2 * VEL_BITS;
    localparam int NQ  = 2 * FRAC_BITS + 1;
    localparam int SPS = ssh_pkg::STEPS_PER_STAGE;
    localparam int NS  = (NQ + SPS - 1) / SPS;

    logic [DW-1:0] r_rem [NS];
    logic [DW-1:0] r_d   [NS];
    logic [NQ-1:0] r_q   [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [DW-1:0] w_rem_in;
        logic [DW-1:0] w_d_in;
        logic [NQ-1:0] w_q_in;
        logic [DW-1:0] n_rem;
        logic [NQ-1:0] n_q;

        if (s == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_d_in   = i_d;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_d_in   = r_d[s-1];
            assign w_q_in   = r_q[s-1];
        end

        always_comb begin
            logic [DW:0] v_try;
            v_try = '0;
            n_rem = w_rem_in;
            n_q   = w_q_in;
            for (int j = 0; j < SPS; j++) begin
                if (s * SPS + j < NQ) begin
                    // the single dividend bit enters on the first step
                    v_try = {n_rem, (s * SPS + j == 0)};
                    if (v_try >= {1'b0, w_d_in}) begin
                        n_rem = DW'(v_try - {1'b0, w_d_in});
                        n_q   = {n_q[NQ-2:0], 1'b1};
                    end else begin
                        n_rem = v_try[DW-1:0];
                        n_q   = {n_q[NQ-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s] <= n_rem;
                r_d[s]   <= w_d_in;
                r_q[s]   <= n_q;
            end
        end
    end

    assign o_q = r_q[NS-1];

endmodule

/* rtl/ssh_isqrt.sv */
// pipelined digit-by-digit truncated square root
module ssh_isqrt #(
    parameter int RAD_W = 96
) (
    input  logic                 i_clk,
    input  logic                 i_ce,
    input  logic [RAD_W-1:0]     i_rad,
    output logic [RAD_W/2-1:0]   o_root
);

    localparam int RB  = RAD_W / 2;
    localparam int SPS = ssh_pkg::STEPS_PER_STAGE;
    localparam int NS  = (RB + SPS - 1) / SPS;

    logic [RB+1:0]    r_rem  [NS];
    logic [RB-1:0]    r_root [NS];
    logic [RAD_W-1:0] r_rad  [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [RB+1:0]    w_rem_in;
        logic [RB-1:0]    w_root_in;
        logic [RAD_W-1:0] w_rad_in;
        logic [RB+1:0]    n_rem;
        logic [RB-1:0]    n_root;
        logic [RAD_W-1:0] n_rad;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in  = r_rad[s-1];
        end

        always_comb begin
            logic [RB+3:0] v_rem2;
            logic [RB+3:0] v_trial;
            v_rem2  = '0;
            v_trial = '0;
            n_rem   = w_rem_in;
            n_root  = w_root_in;
            n_rad   = w_rad_in;
            for (int j = 0; j < SPS; j++) begin
                if (s * SPS + j < RB) begin
                    v_rem2  = {n_rem, n_rad[RAD_W-1:RAD_W-2]};
                    v_trial = (RB+4)'({n_root, 2'b01});
                    if (v_rem2 >= v_trial) begin
                        n_rem  = (RB+2)'(v_rem2 - v_trial);
                        n_root = {n_root[RB-2:0], 1'b1};
                    end else begin
                        n_rem  = v_rem2[RB+1:0];
                        n_root = {n_root[RB-2:0], 1'b0};
                    end
                    n_rad = {n_rad[RAD_W-3:0], 2'b00};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_rad[s]  <= n_rad;
            end
        end
    end

    assign o_root = r_root[NS-1];

endmodule

/* rtl/snell_slowness_horizontal_interface.sv */
// snell's law at a horizontal interface applied to a ray slowness vector
// input stream: one request per ray; tdata holds slow_x, slow_y, slow_z,
// vel_upper, vel_lower from the lowest bit up, tuser holds op
// (0 transmit, 1 reflect); output stream: tdata holds new_slow_x,
// new_slow_y, new_slow_z, tuser holds no_transmission
// one result per request, in order, one request accepted every cycle while the output is not stalled
// the pipeline depth is set by the two reciprocal dividers and the square
// root unit, each retiring four result bits per pipeline stage; RW is the
// radicand width of the square root unit (96 at the default settings)
// the whole pipeline advances when the output register is empty or taken;
// when the receiver stalls every stage holds and tready drops
// reset clears all valid bits; results in flight are dropped
`include "snell_slowness_horizontal_interface_defines.svh"

module snell_slowness_horizontal_interface #(
    parameter int SLOW_FRAC_BITS = 40,
    parameter int VEL_BITS       = 16,
    localparam int IN_W          = 3 * ssh_pkg::SLOW_W + 2 * VEL_BITS,
    localparam int IN_TDATA_W    = ((IN_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // slow_x, slow_y, slow_z, vel_upper, vel_lower, zero fill
    input  logic [IN_TDATA_W-1:0]           i_s_tdata,
    // op
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // new_slow_x, new_slow_y, new_slow_z
    output logic [ssh_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // no_transmission
    output logic                            o_m_tuser
);

    localparam int SW    = ssh_pkg::SLOW_W;
    localparam int HW    = ssh_pkg::HALF_W;
    localparam int DW    = 2 * VEL_BITS;
    localparam int NQ    = 2 * SLOW_FRAC_BITS + 1;
    localparam int SPS   = ssh_pkg::STEPS_PER_STAGE;
    localparam int DL    = (NQ + SPS - 1) / SPS;
    localparam int RW    = ((2 * SLOW_FRAC_BITS > ssh_pkg::MSQ_W - 1) ?
                            2 * SLOW_FRAC_BITS : ssh_pkg::MSQ_W - 1) + 2;
    localparam int RB    = RW / 2;
    localparam int SL    = (RB + SPS - 1) / SPS;
    localparam int P_DIV = 2 + DL;
    localparam int P_RAD = 4 + DL;
    localparam int P_RT  = P_RAD + SL;
    localparam int LAT   = P_RT + 1;

    logic w_ce;

    logic [LAT:1] r_vld;

    // stage 1: input register
    ssh_pkg::t_op        r_op;
    logic [SW-1:0]       r_sx;
    logic [SW-1:0]       r_sy;
    logic [SW-1:0]       r_sz;
    logic [VEL_BITS-1:0] r_vup;
    logic [VEL_BITS-1:0] r_vlo;

    // stage 2: decode
    logic                w_neg;
    logic                w_down;
    logic [SW-1:0]       w_mag;
    logic [VEL_BITS-1:0] w_vt;
    logic [VEL_BITS-1:0] w_vi;
    logic [SW-1:0]       w_refl;
    logic [SW-1:0]       r_mag;
    logic [DW-1:0]       r_dt;
    logic [DW-1:0]       r_di;

    ssh_pkg::t_side      r_side [2:P_RT];

    // magnitude square
    logic [2*HW-1:0]            r_hh;
    logic [2*HW-1:0]            r_hl;
    logic [2*HW-1:0]            r_ll;
    logic [ssh_pkg::MSQ_W-1:0]  r_msq [4:P_DIV];

    logic [NQ-1:0] w_rt;
    logic [NQ-1:0] w_ri;
    logic [RW-1:0] r_pos;
    logic [RW-1:0] r_ri;
    logic [RW-1:0] r_rad;
    logic          r_fl [P_RAD:P_RT];
    logic [RB-1:0] w_root;

    logic [SW-1:0] w_root_sat;
    logic [SW-1:0] n_out_z;
    logic          n_out_fl;
    logic [SW-1:0] r_out_x;
    logic [SW-1:0] r_out_y;
    logic [SW-1:0] r_out_z;
    logic          r_out_fl;

    assign w_ce       = !r_vld[LAT] || i_m_tready;
    assign o_s_tready = w_ce;
    assign o_m_tvalid = r_vld[LAT];
    assign o_m_tdata  = {r_out_z, r_out_y, r_out_x};
    assign o_m_tuser  = r_out_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LAT-1:1], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_op  <= ssh_pkg::t_op'(i_s_tuser);
            r_sx  <= i_s_tdata[SW-1:0];
            r_sy  <= i_s_tdata[2*SW-1:SW];
            r_sz  <= i_s_tdata[3*SW-1:2*SW];
            r_vup <= i_s_tdata[3*SW+VEL_BITS-1:3*SW];
            r_vlo <= i_s_tdata[3*SW+2*VEL_BITS-1:3*SW+VEL_BITS];
        end
    end

    always_comb begin
        w_neg  = r_sz[SW-1];
        w_down = !w_neg && (r_sz != '0);
        w_mag  = w_neg ? (~r_sz + SW'(1)) : r_sz;
        w_vt   = w_down ? r_vlo : r_vup;
        w_vi   = w_down ? r_vup : r_vlo;
        // zero velocity counts as one
        if (w_vt == '0) begin
            w_vt = VEL_BITS'(1);
        end
        if (w_vi == '0) begin
            w_vi = VEL_BITS'(1);
        end
        w_refl = (r_sz == ssh_pkg::SLOW_MIN) ? ssh_pkg::SLOW_MAX : (~r_sz + SW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_mag          <= w_mag;
            r_dt           <= DW'(w_vt) * DW'(w_vt);
            r_di           <= DW'(w_vi) * DW'(w_vi);
            r_side[2].op   <= r_op;
            r_side[2].neg  <= w_neg;
            r_side[2].sx   <= r_sx;
            r_side[2].sy   <= r_sy;
            r_side[2].refl <= w_refl;
            for (int k = 3; k <= P_RT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_hh     <= r_mag[2*HW-1:HW] * r_mag[2*HW-1:HW];
            r_hl     <= r_mag[2*HW-1:HW] * r_mag[HW-1:0];
            r_ll     <= r_mag[HW-1:0] * r_mag[HW-1:0];
            r_msq[4] <= ssh_pkg::MSQ_W'({r_hh, {(2*HW){1'b0}}}
                        + {{(HW-1){1'b0}}, r_hl, {(HW+1){1'b0}}}
                        + {{(2*HW){1'b0}}, r_ll});
            for (int k = 5; k <= P_DIV; k++) begin
                r_msq[k] <= r_msq[k-1];
            end
        end
    end

    ssh_recip #(
        .FRAC_BITS (SLOW_FRAC_BITS),
        .VEL_BITS  (VEL_BITS)
    ) u_recip_t (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_d   (r_dt),
        .o_q   (w_rt)
    );

    ssh_recip #(
        .FRAC_BITS (SLOW_FRAC_BITS),
        .VEL_BITS  (VEL_BITS)
    ) u_recip_i (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_d   (r_di),
        .o_q   (w_ri)
    );

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_pos        <= RW'(w_rt) + RW'(r_msq[P_DIV]);
            r_ri         <= RW'(w_ri);
            r_rad        <= r_pos - r_ri;
            r_fl[P_RAD]  <= (r_pos < r_ri);
            for (int k = P_RAD + 1; k <= P_RT; k++) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    ssh_isqrt #(
        .RAD_W (RW)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    always_comb begin
        w_root_sat = (w_root > RB'(ssh_pkg::SLOW_MAX)) ? ssh_pkg::SLOW_MAX : w_root[SW-1:0];
        if (r_side[P_RT].op == ssh_pkg::OP_REFLECT) begin
            n_out_z  = r_side[P_RT].refl;
            n_out_fl = 1'b0;
        end else if (r_fl[P_RT]) begin
            n_out_z  = '0;
            n_out_fl = 1'b1;
        end else begin
            n_out_z  = r_side[P_RT].neg ? (~w_root_sat + SW'(1)) : w_root_sat;
            n_out_fl = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_x  <= r_side[P_RT].sx;
            r_out_y  <= r_side[P_RT].sy;
            r_out_z  <= n_out_z;
            r_out_fl <= n_out_fl;
        end
    end

    `SSH_ASSERT_SAME(a_flag_zero_z, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata[3*SW-1:2*SW] == '0)
    `SSH_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, o_s_tready && !i_s_tvalid, !r_vld[1])
    `SSH_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !o_s_tready, $stable(r_vld))

endmodule

/* bench/tb_top.sv */
// testbench for the snell slowness interface block: random and directed rays, checked in order
`timescale 1ns / 100ps

module tb_top;

    localparam int SFB = 40;
    localparam int IN_TDW = 176;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        ssh_pkg::t_op op;
        logic [47:0]  sx;
        logic [47:0]  sy;
        logic [47:0]  sz;
        logic [15:0]  vu;
        logic [15:0]  vl;
    } t_ray;

    typedef struct packed {
        logic [47:0] nx;
        logic [47:0] ny;
        logic [47:0] nz;
        logic        nt;
    } t_bent;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [IN_TDW-1:0] i_s_tdata = '0;
    logic i_s_tuser = 1'b0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [ssh_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic o_m_tuser;

    t_ray  pending_rays[$];
    t_bent bent_rays[$];
    int    errors = 0;
    longint cycle = 0;
    bit    all_queued = 1'b0;
    bit    calm = 1'b0;
    int    hold_off = 0;
    bit    drain_wait = 1'b0;

    snell_slowness_horizontal_interface u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [127:0] recip_sq(logic [15:0] v);
        logic [127:0] d;
        d = v * v;
        if (d == 0) d = 1;
        return (128'd1 << (2 * SFB)) / d;
    endfunction

    function automatic logic [63:0] isqrt128(logic [127:0] n);
        logic [63:0] r;
        logic [127:0] sq;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            sq = {64'd0, r | (64'd1 << b)} * {64'd0, r | (64'd1 << b)};
            if (sq <= n) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic t_bent bend_ray(t_ray r);
        t_bent b;
        logic neg, down;
        logic [47:0] mag, vt, vi;
        logic [127:0] pos, sub;
        logic [63:0] s;
        b.nx = r.sx;
        b.ny = r.sy;
        b.nt = 1'b0;
        if (r.op == ssh_pkg::OP_REFLECT) begin
            b.nz = (r.sz == ssh_pkg::SLOW_MIN) ? ssh_pkg::SLOW_MAX : -r.sz;
        end else begin
            neg = r.sz[47];
            down = !neg && r.sz != 0;
            mag = neg ? -r.sz : r.sz;
            vt = down ? r.vl : r.vu;
            vi = down ? r.vu : r.vl;
            pos = recip_sq(vt[15:0]) + {80'd0, mag} * {80'd0, mag};
            sub = recip_sq(vi[15:0]);
            if (pos < sub) begin
                b.nz = 0;
                b.nt = 1'b1;
            end else begin
                s = isqrt128(pos - sub);
                if (s > {16'd0, ssh_pkg::SLOW_MAX}) s = {16'd0, ssh_pkg::SLOW_MAX};
                b.nz = neg ? -s[47:0] : s[47:0];
            end
        end
        return b;
    endfunction

    function automatic logic [47:0] rand_slow();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 47);
            1: v = -(v >> $urandom_range(0, 47));
            2: v = {{8{v[39]}}, v[39:0]} >>> $urandom_range(0, 12);
            default: v = $signed(v[31:0]) >>> $urandom_range(0, 20);
        endcase
        return v;
    endfunction

    function automatic t_ray rand_ray();
        t_ray r;
        r.op = ssh_pkg::t_op'($urandom_range(0, 3) == 0);
        r.sx = rand_slow();
        r.sy = rand_slow();
        r.sz = rand_slow();
        r.vu = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1000, 8000));
        r.vl = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1000, 8000));
        return r;
    endfunction

    function automatic t_ray mk(ssh_pkg::t_op op, logic [47:0] sz, logic [15:0] vu,
                                logic [15:0] vl);
        t_ray r;
        r.op = op;
        r.sx = 48'({$urandom, $urandom});
        r.sy = 48'({$urandom, $urandom});
        r.sz = sz;
        r.vu = vu;
        r.vl = vl;
        return r;
    endfunction

    initial begin
        t_ray r;
        pending_rays.push_back(mk(ssh_pkg::OP_REFLECT, ssh_pkg::SLOW_MIN, 1, 1));
        pending_rays.push_back(mk(ssh_pkg::OP_REFLECT, ssh_pkg::SLOW_MAX, 65535, 0));
        pending_rays.push_back(mk(ssh_pkg::OP_REFLECT, 0, 3000, 2000));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, 0, 2000, 3000));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, 0, 3000, 2000));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, 0, 2000, 2000));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, ssh_pkg::SLOW_MAX, 1, 65535));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, ssh_pkg::SLOW_MIN, 65535, 1));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, ssh_pkg::SLOW_MIN, 1, 65535));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, 48'd1, 0, 0));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, -48'd1, 0, 65535));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, 48'd100000000, 2000, 4000));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, -48'd100000000, 2000, 4000));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, 48'd549755813, 2000, 2000));
        pending_rays.push_back(mk(ssh_pkg::OP_TRANSMIT, 48'd100, 65535, 65535));
        r = mk(ssh_pkg::OP_TRANSMIT, ssh_pkg::SLOW_MAX, 16'hffff, 16'hffff);
        r.sx = ssh_pkg::SLOW_MAX; r.sy = ssh_pkg::SLOW_MIN;
        pending_rays.push_back(r);
        r.sx = 0; r.sy = '1; r.op = ssh_pkg::OP_REFLECT;
        pending_rays.push_back(r);
        for (int i = 0; i < 1250; i++) pending_rays.push_back(rand_ray());
        all_queued = 1'b1;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle == 10) i_rst_n <= 1'b1;
        if (cycle == 900) calm <= 1'b1;
        if (cycle == 1300) calm <= 1'b0;
        if (cycle == LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) pending_rays.pop_front();
            if (cycle == 1600) drain_wait <= 1'b1;
            if (drain_wait && bent_rays.size() == 0 && !(i_s_tvalid && o_s_tready)) begin
                drain_wait <= 1'b0;
            end
            if (i_s_tvalid && !o_s_tready) begin
            end else if (pending_rays.size() > 0 && !drain_wait
                         && (calm || $urandom_range(0, 99) >= 28)) begin
                t_ray r;
                r = pending_rays[0];
                i_s_tvalid <= 1'b1;
                i_s_tuser <= r.op;
                i_s_tdata <= {r.vl, r.vu, r.sz, r.sy, r.sx};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // predictor taps accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            t_ray r;
            r.op = ssh_pkg::t_op'(i_s_tuser);
            {r.vl, r.vu, r.sz, r.sy, r.sx} = i_s_tdata;
            bent_rays.push_back(bend_ray(r));
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cycle == 300) hold_off <= 400;
            else if (hold_off > 0) hold_off <= hold_off - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_m_tready <= (hold_off <= 1) && (calm || $urandom_range(0, 99) >= 28);
            if (o_m_tvalid && i_m_tready) begin
                if (bent_rays.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    t_bent e;
                    e = bent_rays.pop_front();
                    if (o_m_tdata[47:0] !== e.nx) begin
                        $error("new_slow_x exp %h got %h", e.nx, o_m_tdata[47:0]);
                        errors++;
                    end
                    if (o_m_tdata[95:48] !== e.ny) begin
                        $error("new_slow_y exp %h got %h", e.ny, o_m_tdata[95:48]);
                        errors++;
                    end
                    if (o_m_tdata[143:96] !== e.nz) begin
                        $error("new_slow_z exp %h got %h", e.nz, o_m_tdata[143:96]);
                        errors++;
                    end
                    if (o_m_tuser !== e.nt) begin
                        $error("no_transmission exp %b got %b", e.nt, o_m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        wait (all_queued && i_rst_n);
        wait (pending_rays.size() == 0 && !i_s_tvalid);
        wait (bent_rays.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && bent_rays.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/ssh_pkg.sv
rtl/ssh_recip.sv
rtl/ssh_isqrt.sv
rtl/snell_slowness_horizontal_interface.sv
bench/tb_top.sv
